@@ rtl/core/assert_macros.svh @@
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ROB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Condition that must never be seen outside reset.
`define ROB_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/core/rob_pkg.sv @@
`default_nettype none
package rob_pkg;

  localparam int unsigned REG_BITS   = 48;
  localparam int unsigned AXIS_BITS  = 16;
  localparam int unsigned IN_BITS    = 16;
  localparam int unsigned PD_BITS    = 34;
  localparam int unsigned DVS_BITS   = 32;
  localparam int unsigned FRAC_SHIFT = 14;
  localparam int signed   PAR_EPS    = 268;
  localparam logic [15:0] DIST_MAX   = 16'hFFFF;

  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AXIS_U  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AXIS_V  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AXIS_W  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EXTENTS = 3'd4;

  // Dividend width of the slab divider for a given coordinate width.
  function automatic int unsigned quo_bits(int unsigned cb);
    int unsigned cw;
    cw = (cb > 16) ? cb : 16;
    return cw + 1 + AXIS_BITS + 2 + 1 + FRAC_SHIFT;
  endfunction

  // Cycles from the edge that takes a request to the edge that takes its result.
  function automatic int unsigned pipe_latency(int unsigned cb);
    return quo_bits(cb) + 7;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/rob_div.sv @@
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, two dividends
// sharing one divisor.
module rob_div #(
  parameter int unsigned NB = 50,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic [NB-1:0] dvd_a_i,
  input  wire logic [NB-1:0] dvd_b_i,
  input  wire logic [DW-1:0] dvs_i,
  output logic      [NB-1:0] quo_a_o,
  output logic      [NB-1:0] quo_b_o
);

  logic [DW-1:0] rem_a_q [NB];
  logic [DW-1:0] rem_b_q [NB];
  logic [NB-1:0] sh_a_q  [NB];
  logic [NB-1:0] sh_b_q  [NB];
  logic [DW-1:0] dvs_q   [NB];

  for (genvar s = 0; s < NB; s++) begin : g_stage
    logic [DW-1:0] rem_a_in, rem_b_in, dvs_in;
    logic [NB-1:0] sh_a_in, sh_b_in;
    logic [DW:0]   tr_a, tr_b, df_a, df_b;
    logic          ge_a, ge_b;

    if (s == 0) begin : g_first
      assign rem_a_in = '0;
      assign rem_b_in = '0;
      assign sh_a_in  = dvd_a_i;
      assign sh_b_in  = dvd_b_i;
      assign dvs_in   = dvs_i;
    end else begin : g_next
      assign rem_a_in = rem_a_q[s-1];
      assign rem_b_in = rem_b_q[s-1];
      assign sh_a_in  = sh_a_q[s-1];
      assign sh_b_in  = sh_b_q[s-1];
      assign dvs_in   = dvs_q[s-1];
    end

    // Bring down the next dividend bit, subtract when it fits.
    assign tr_a = {rem_a_in, sh_a_in[NB-1]};
    assign tr_b = {rem_b_in, sh_b_in[NB-1]};
    assign ge_a = tr_a >= {1'b0, dvs_in};
    assign ge_b = tr_b >= {1'b0, dvs_in};
    assign df_a = tr_a - {1'b0, dvs_in};
    assign df_b = tr_b - {1'b0, dvs_in};

    always_ff @(posedge clk_i) begin
      rem_a_q[s] <= ge_a ? df_a[DW-1:0] : tr_a[DW-1:0];
      rem_b_q[s] <= ge_b ? df_b[DW-1:0] : tr_b[DW-1:0];
      sh_a_q[s]  <= {sh_a_in[NB-2:0], ge_a};
      sh_b_q[s]  <= {sh_b_in[NB-2:0], ge_b};
      dvs_q[s]   <= dvs_in;
    end
  end

  assign quo_a_o = sh_a_q[NB-1];
  assign quo_b_o = sh_b_q[NB-1];

endmodule
`default_nettype wire

@@ rtl/core/ray_oriented_box_intersect_unit.sv @@
`default_nettype none
// Ray versus oriented box slab test. A request is taken at every clock edge
// where start is high; busy never rises, so one ray can enter per clock. The
// result appears on hit_o, hit_distance_o and box_crossed_o for exactly one
// cycle, marked by done_o. The receiver cannot hold it off, so it must sample
// on every done_o. Results leave in request order. The latency is set by the
// slab dividers, which resolve one quotient bit per stage; the rest is four
// stages in front (offset, axis products, projection sums, slab bounds) and
// three behind (sign and order, interval merge, result). Configuration writes
// are always ready and take effect at once, so write the box only while no
// request is in flight.
module ray_oriented_box_intersect_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [47:0]        cfg_data_i,
  input  wire logic signed [15:0] origin_x_i,
  input  wire logic signed [15:0] origin_y_i,
  input  wire logic signed [15:0] origin_z_i,
  input  wire logic signed [15:0] dir_x_i,
  input  wire logic signed [15:0] dir_y_i,
  input  wire logic signed [15:0] dir_z_i,
  input  wire logic [15:0]        max_distance_i,
  output logic                    done_o,
  output logic                    hit_o,
  output logic [15:0]             hit_distance_o,
  output logic                    box_crossed_o
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned RB   = rob_pkg::REG_BITS;
  localparam int unsigned AB   = rob_pkg::AXIS_BITS;
  localparam int unsigned FS   = rob_pkg::FRAC_SHIFT;
  localparam int unsigned PDW  = rob_pkg::PD_BITS;
  localparam int unsigned DVW  = rob_pkg::DVS_BITS;
  localparam int unsigned CW   = (CB > 16) ? CB : 16;
  localparam int unsigned OW   = CW + 1;
  localparam int unsigned PRW  = OW + AB;
  localparam int unsigned POW  = PRW + 2;
  localparam int unsigned SW   = POW + 1;
  localparam int unsigned HW   = CB + FS + 1;
  localparam int unsigned NB   = rob_pkg::quo_bits(CB);
  localparam int unsigned TW   = NB + 2;
  localparam int unsigned WIDE = 3 * CB + RB;

  typedef struct packed {
    logic [15:0] maxd;
    logic [2:0]  nonpar;
    logic [2:0]  parok;
    logic [2:0]  neg_a;
    logic [2:0]  neg_b;
  } side_t;

  // No back-pressure: take a request on every cycle it is offered.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------- box regs
  logic [RB-1:0] center_q, axis_u_q, axis_v_q, axis_w_q, extents_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q  <= '0;
      axis_u_q  <= '0;
      axis_v_q  <= '0;
      axis_w_q  <= '0;
      extents_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rob_pkg::CFG_CENTER:  center_q  <= cfg_data_i;
        rob_pkg::CFG_AXIS_U:  axis_u_q  <= cfg_data_i;
        rob_pkg::CFG_AXIS_V:  axis_v_q  <= cfg_data_i;
        rob_pkg::CFG_AXIS_W:  axis_w_q  <= cfg_data_i;
        rob_pkg::CFG_EXTENTS: extents_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the box fields; coordinate fields reaching past the register read
  // zero in the missing bits.
  logic [WIDE-1:0]         center_wide, ext_wide;
  logic signed [CB-1:0]    cfield [3];
  logic [CB-1:0]           efield [3];
  logic signed [AB-1:0]    ax     [3][3];
  logic signed [rob_pkg::IN_BITS-1:0] org [3];
  logic signed [rob_pkg::IN_BITS-1:0] dir [3];

  assign center_wide = WIDE'(center_q);
  assign ext_wide    = WIDE'(extents_q);
  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cfield[k] = $signed(center_wide[k*CB +: CB]);
      efield[k] = ext_wide[k*CB +: CB];
      ax[0][k]  = $signed(axis_u_q[k*AB +: AB]);
      ax[1][k]  = $signed(axis_v_q[k*AB +: AB]);
      ax[2][k]  = $signed(axis_w_q[k*AB +: AB]);
    end
  end

  // ------------------------------------------- stage 1: offset center-origin
  logic                 s1_v_q;
  logic signed [OW-1:0] off_q  [3];
  logic signed [AB-1:0] dir1_q [3];
  logic [15:0]          mx1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      off_q[k]  <= OW'(cfield[k]) - OW'(org[k]);
      dir1_q[k] <= dir[k];
    end
    mx1_q <= max_distance_i;
  end

  // -------------------------------------------- stage 2: per-axis products
  logic                     s2_v_q;
  logic signed [PRW-1:0]    pop_q [3][3];
  logic signed [2*AB-1:0]   pdp_q [3][3];
  logic [15:0]              mx2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        pop_q[i][k] <= PRW'(ax[i][k]) * PRW'(off_q[k]);
        pdp_q[i][k] <= (2*AB)'(ax[i][k]) * (2*AB)'(dir1_q[k]);
      end
    end
    mx2_q <= mx1_q;
  end

  // ------------------------------------------ stage 3: projection sums
  logic                  s3_v_q;
  logic signed [POW-1:0] po_q [3];
  logic signed [PDW-1:0] pd_q [3];
  logic [15:0]           mx3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      po_q[i] <= POW'(pop_q[i][0]) + POW'(pop_q[i][1]) + POW'(pop_q[i][2]);
      pd_q[i] <= PDW'(pdp_q[i][0]) + PDW'(pdp_q[i][1]) + PDW'(pdp_q[i][2]);
    end
    mx3_q <= mx2_q;
  end

  // --------------------------- stage 4: slab bounds, parallel test, magnitudes
  logic signed [HW-1:0]  h     [3];
  logic signed [SW-1:0]  num_a [3];
  logic signed [SW-1:0]  num_b [3];
  logic [SW-1:0]         mag_a [3];
  logic [SW-1:0]         mag_b [3];
  logic signed [PDW-1:0] pd_abs[3];
  side_t                 side4;

  always_comb begin
    side4      = '0;
    side4.maxd = mx3_q;
    for (int i = 0; i < 3; i++) begin
      h[i]     = $signed({1'b0, efield[i], {FS{1'b0}}});
      num_a[i] = SW'(po_q[i]) + SW'(h[i]);
      num_b[i] = SW'(po_q[i]) - SW'(h[i]);
      mag_a[i] = num_a[i][SW-1] ? SW'(-num_a[i]) : SW'(num_a[i]);
      mag_b[i] = num_b[i][SW-1] ? SW'(-num_b[i]) : SW'(num_b[i]);
      pd_abs[i] = pd_q[i][PDW-1] ? -pd_q[i] : pd_q[i];
      side4.nonpar[i] = (pd_q[i] > PDW'(rob_pkg::PAR_EPS)) ||
                        (pd_q[i] < -PDW'(rob_pkg::PAR_EPS));
      // A parallel ray must start between the two slab planes.
      side4.parok[i]  = !num_a[i][SW-1] && (num_b[i][SW-1] || (num_b[i] == '0));
      // Truncating division: the quotient takes the xor of the signs.
      side4.neg_a[i]  = num_a[i][SW-1] ^ pd_q[i][PDW-1];
      side4.neg_b[i]  = num_b[i][SW-1] ^ pd_q[i][PDW-1];
    end
  end

  logic           s4_v_q;
  side_t          side4_q;
  logic [NB-1:0]  dvd_a_q [3];
  logic [NB-1:0]  dvd_b_q [3];
  logic [DVW-1:0] dvs_q   [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dvd_a_q[i] <= {mag_a[i], {FS{1'b0}}};
      dvd_b_q[i] <= {mag_b[i], {FS{1'b0}}};
      dvs_q[i]   <= pd_abs[i][DVW-1:0];
    end
    side4_q <= side4;
  end

  // ----------------------------------------------- slab dividers, one per axis
  logic [NB-1:0] quo_a [3];
  logic [NB-1:0] quo_b [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    rob_div #(
      .NB (NB),
      .DW (DVW)
    ) u_div (
      .clk_i   (clk_i),
      .dvd_a_i (dvd_a_q[i]),
      .dvd_b_i (dvd_b_q[i]),
      .dvs_i   (dvs_q[i]),
      .quo_a_o (quo_a[i]),
      .quo_b_o (quo_b[i])
    );
  end

  // Carry flags and valid alongside the divider stages.
  side_t         dly_q [NB];
  logic [NB-1:0] dly_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_v_q <= '0;
    end else begin
      dly_v_q <= {dly_v_q[NB-2:0], s4_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    dly_q[0] <= side4_q;
    for (int j = 1; j < NB; j++) begin
      dly_q[j] <= dly_q[j-1];
    end
  end

  // ------------------------------------------ stage 5: sign and order
  logic signed [TW-1:0] ta [3];
  logic signed [TW-1:0] tb [3];
  side_t                side_last;

  assign side_last = dly_q[NB-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ta[i] = side_last.neg_a[i] ? -$signed(TW'(quo_a[i])) : $signed(TW'(quo_a[i]));
      tb[i] = side_last.neg_b[i] ? -$signed(TW'(quo_b[i])) : $signed(TW'(quo_b[i]));
    end
  end

  logic                 s5_v_q;
  logic signed [TW-1:0] lo5_q [3];
  logic signed [TW-1:0] hi5_q [3];
  side_t                side5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else begin
      s5_v_q <= dly_v_q[NB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      lo5_q[i] <= (ta[i] < tb[i]) ? ta[i] : tb[i];
      hi5_q[i] <= (ta[i] < tb[i]) ? tb[i] : ta[i];
    end
    side5_q <= side_last;
  end

  // ------------------------------------------ stage 6: interval merge
  localparam logic signed [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};

  logic signed [TW-1:0] tlo_d, thi_d;

  always_comb begin
    tlo_d = T_MIN;
    thi_d = T_MAX;
    for (int i = 0; i < 3; i++) begin
      // Parallel axes leave the interval open.
      if (side5_q.nonpar[i] && (lo5_q[i] > tlo_d)) begin
        tlo_d = lo5_q[i];
      end
      if (side5_q.nonpar[i] && (hi5_q[i] < thi_d)) begin
        thi_d = hi5_q[i];
      end
    end
  end

  logic                 s6_v_q;
  logic signed [TW-1:0] tlo_q, thi_q;
  logic                 ok6_q;
  logic [15:0]          mx6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tlo_q <= tlo_d;
    thi_q <= thi_d;
    ok6_q <= &(side5_q.nonpar | side5_q.parok);
    mx6_q <= side5_q.maxd;
  end

  // ------------------------------------------ stage 7: result
  logic                 crossed;
  logic signed [TW-1:0] rep_dist;
  logic [15:0]          dist_sat;

  always_comb begin
    crossed = ok6_q && !(tlo_q > thi_q) && !thi_q[TW-1];
    // Report the exit when the origin is inside or on the box.
    rep_dist = (tlo_q > 0) ? tlo_q : thi_q;
    if (rep_dist > $signed(TW'(rob_pkg::DIST_MAX))) begin
      dist_sat = rob_pkg::DIST_MAX;
    end else if (rep_dist[TW-1]) begin
      dist_sat = '0;
    end else begin
      dist_sat = rep_dist[15:0];
    end
  end

  logic        done_q, hit_q, crossed_q;
  logic [15:0] dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    crossed_q <= crossed;
    hit_q     <= crossed && (rep_dist <= $signed(TW'(mx6_q)));
    dist_q    <= crossed ? dist_sat : '0;
  end

  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign hit_distance_o = dist_q;
  assign box_crossed_o  = crossed_q;

endmodule
`default_nettype wire

@@ rtl/core/rob_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module rob_checker #(
  parameter int unsigned COORD_BITS = 16
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic        hit_o,
  input wire logic [15:0] hit_distance_o,
  input wire logic        box_crossed_o
);

  localparam int unsigned LAT = rob_pkg::pipe_latency(COORD_BITS);

  // A result only ever follows a request by the fixed pipeline latency.
  `ROB_ASSERT_IMP(a_done_latency, clk_i, rst_ni, done_o, $past(start && !busy, LAT))
  // A miss reports zero distance and no hit.
  `ROB_ASSERT_IMP(a_miss_clean, clk_i, rst_ni, done_o && !box_crossed_o, !hit_o && (hit_distance_o == 16'd0))
  // A hit without crossing the box is impossible.
  `ROB_ASSERT_NEVER(a_hit_crossed, clk_i, rst_ni, done_o && hit_o && !box_crossed_o)

endmodule

bind ray_oriented_box_intersect_unit rob_checker #(.COORD_BITS(COORD_BITS)) u_rob_checker (.*);
`default_nettype wire
